// File: sv/mnlq_pkg.sv
// Shared types, codes and constants of the neighbor link quality table.
package mnlq_pkg;

  localparam int SLOTS_DEF = 8;
  localparam int ADDR_W    = 16;
  localparam int IDX_W     = 6;   // wide enough for 64 slots
  localparam int CNT_W     = 7;   // holds a count of up to 64
  localparam int ETX_W     = 8;
  localparam int RSSI_W    = 8;
  localparam int TXC_W     = 8;
  localparam int LOSS_W    = 10;
  localparam int COST_W    = 16;
  localparam int NUM_W     = 18;  // attempts-acks times 1000
  localparam int IN_DATA_W = 48;
  localparam int IN_USER_W = 3;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_USER_W = 4;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [2:0] OP_FIND  = 3'd0;
  localparam logic [2:0] OP_ALLOC = 3'd1;
  localparam logic [2:0] OP_TX    = 3'd2;
  localparam logic [2:0] OP_RSSI  = 3'd3;
  localparam logic [2:0] OP_ROOM  = 3'd4;
  localparam logic [2:0] OP_FREE  = 3'd5;
  localparam logic [2:0] OP_SET   = 3'd6;
  localparam logic [2:0] OP_COUNT = 3'd7;

  localparam logic [1:0] ST_FREE   = 2'd0;
  localparam logic [1:0] ST_HEARD  = 2'd1;
  localparam logic [1:0] ST_LINKED = 2'd2;
  localparam logic [1:0] ST_LOST   = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_MISS    = 2'd1;
  localparam logic [1:0] STAT_BADADDR = 2'd2;

  localparam logic [1:0] KIND_FREE     = 2'd0;
  localparam logic [1:0] KIND_UNLINKED = 2'd1;
  localparam logic [1:0] KIND_LINKED   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_EWMA    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEAK    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PENALTY = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INVALID = 8'd3;

  localparam logic [ETX_W-1:0]  ETX_ONE    = 8'd16;
  localparam logic [ETX_W-1:0]  ETX_LOSS   = 8'd64;
  localparam logic [ETX_W-1:0]  ETX_CEIL   = 8'd128;
  localparam logic [RSSI_W-1:0] RSSI_NONE  = 8'h80;
  localparam logic [COST_W-1:0] COST_MAX   = 16'd65534;
  localparam logic [COST_W-1:0] COST_FRESH = 16'hFFFF;
  localparam logic [TXC_W-1:0]  HALVE_AT   = 8'd128;
  localparam logic [LOSS_W-1:0] PERMILLE   = 10'd1000;

  typedef struct packed {
    logic [1:0]               st;
    logic [ADDR_W-1:0]        addr;
    logic [ETX_W-1:0]         etx;
    logic signed [RSSI_W-1:0] rssi;
    logic [TXC_W-1:0]         att;
    logic [TXC_W-1:0]         ack;
    logic [LOSS_W-1:0]        loss;
    logic [COST_W-1:0]        cost;
    logic                     par;
  } entry_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [COST_W-1:0] cand;
  } key_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    entry_t           ent;
  } wr_t;

  // Partial result of a scan, handed from cell to cell.
  typedef struct packed {
    logic              vld;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    entry_t            hit_ent;
    logic              free;
    logic [IDX_W-1:0]  free_idx;
    logic              unl;
    logic [IDX_W-1:0]  unl_idx;
    logic [COST_W-1:0] unl_cost;
    logic [ADDR_W-1:0] unl_addr;
    logic              lnk;
    logic [IDX_W-1:0]  lnk_idx;
    logic [COST_W-1:0] lnk_cost;
    logic [ADDR_W-1:0] lnk_addr;
    logic [CNT_W-1:0]  nlinked;
  } scan_t;

endpackage

// File: sv/mnlq_div.sv
// Restoring divider for the loss rate, one quotient bit per cycle.
module mnlq_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [mnlq_pkg::NUM_W-1:0]           num,
  input  logic [mnlq_pkg::TXC_W-1:0]           den,
  output logic                                 done,
  output logic [mnlq_pkg::LOSS_W-1:0]          quo
);

  localparam int CW = $clog2(mnlq_pkg::NUM_W + 1);

  logic [mnlq_pkg::TXC_W-1:0] rem;
  logic [mnlq_pkg::NUM_W-1:0] q;
  logic [CW-1:0]              cnt;
  logic                       busy;
  logic [mnlq_pkg::TXC_W:0]   trial;
  logic                       take;

  assign trial = {rem, q[mnlq_pkg::NUM_W-1]};
  assign take  = trial >= {1'b0, den};
  assign quo   = q[mnlq_pkg::LOSS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(mnlq_pkg::NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= num;
    end else if (busy) begin
      rem <= take ? mnlq_pkg::TXC_W'(trial - {1'b0, den}) : trial[mnlq_pkg::TXC_W-1:0];
      q   <= {q[mnlq_pkg::NUM_W-2:0], take};
    end
  end

endmodule

// File: sv/mnlq_cell.sv
// One table slot: holds its entry and folds it into the passing scan beat.
module mnlq_cell #(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  mnlq_pkg::key_t  key,
  input  mnlq_pkg::wr_t   wr,
  input  mnlq_pkg::scan_t scan_in,
  output mnlq_pkg::scan_t scan_out
);

  mnlq_pkg::entry_t ent;
  mnlq_pkg::scan_t  nxt;
  logic             occ;
  logic [mnlq_pkg::COST_W:0] limit;

  assign occ   = ent.st != mnlq_pkg::ST_FREE;
  assign limit = {1'b0, key.cand} + (mnlq_pkg::COST_W+1)'(mnlq_pkg::ETX_ONE);

  always_comb begin
    nxt = scan_in;
    if (!scan_in.hit && occ && ent.addr == key.addr) begin
      nxt.hit     = 1'b1;
      nxt.hit_idx = mnlq_pkg::IDX_W'(IDX);
      nxt.hit_ent = ent;
    end
    if (!scan_in.free && !occ) begin
      nxt.free     = 1'b1;
      nxt.free_idx = mnlq_pkg::IDX_W'(IDX);
    end
    // strict compare keeps the lowest slot on a tie
    if ((ent.st == mnlq_pkg::ST_HEARD || ent.st == mnlq_pkg::ST_LOST) &&
        (!scan_in.unl || ent.cost > scan_in.unl_cost)) begin
      nxt.unl      = 1'b1;
      nxt.unl_idx  = mnlq_pkg::IDX_W'(IDX);
      nxt.unl_cost = ent.cost;
      nxt.unl_addr = ent.addr;
    end
    if (!ent.par && {1'b0, ent.cost} > limit &&
        (!scan_in.lnk || ent.cost > scan_in.lnk_cost)) begin
      nxt.lnk      = 1'b1;
      nxt.lnk_idx  = mnlq_pkg::IDX_W'(IDX);
      nxt.lnk_cost = ent.cost;
      nxt.lnk_addr = ent.addr;
    end
    if (ent.st == mnlq_pkg::ST_LINKED) begin
      nxt.nlinked = scan_in.nlinked + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent      <= '0;
      scan_out <= '0;
    end else begin
      if (wr.en && wr.idx == mnlq_pkg::IDX_W'(IDX)) begin
        ent <= wr.ent;
      end
      scan_out <= nxt;
    end
  end

endmodule

// File: sv/mnlq_ctrl.sv
// Sequencer: takes a request, runs the slot scan, updates metrics, writes back.
module mnlq_ctrl (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [mnlq_pkg::IN_DATA_W-1:0]        s_tdata,
  input  logic [mnlq_pkg::IN_USER_W-1:0]        s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [mnlq_pkg::OUT_DATA_W-1:0]       m_tdata,
  output logic [mnlq_pkg::OUT_USER_W-1:0]       m_tuser,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mnlq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mnlq_pkg::CFG_DATA_W-1:0]       cfg_data,
  output mnlq_pkg::key_t                        key,
  output mnlq_pkg::scan_t                       scan_init,
  input  mnlq_pkg::scan_t                       scan_res,
  output mnlq_pkg::wr_t                         wr
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_MATH = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state;

  // configuration
  logic [2:0]        ewma_shift;
  logic signed [7:0] weak_rssi;
  logic [3:0]        penalty;
  logic [15:0]       invalid_addr;

  // request
  logic [2:0]                    op_q;
  logic [mnlq_pkg::ADDR_W-1:0]   addr_q;
  logic                          ack_q;
  logic signed [7:0]             rs_q;
  logic [mnlq_pkg::COST_W-1:0]   cand_q;
  logic [1:0]                    nst_q;
  logic                          par_q;
  logic                          start_q;
  mnlq_pkg::scan_t               sr;

  // transmit result work
  logic [mnlq_pkg::ETX_W-1:0]  etx_q;
  logic [mnlq_pkg::TXC_W-1:0]  att_q;
  logic [mnlq_pkg::TXC_W-1:0]  ak_q;
  logic [mnlq_pkg::TXC_W-1:0]  den_q;
  logic [mnlq_pkg::NUM_W-1:0]  num_q;
  logic                        div_start;
  logic                        div_done;
  logic [mnlq_pkg::LOSS_W-1:0] div_quo;

  mnlq_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_q),
    .den   (den_q),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign s_tready  = state == S_IDLE;
  assign cfg_ready = 1'b1;
  assign key.addr  = addr_q;
  assign key.cand  = cand_q;

  always_comb begin
    scan_init     = '0;
    scan_init.vld = start_q;
  end

  // ETX step for the transmit result
  logic [8:0]        att9, ak9;
  logic signed [9:0] e_old, e_smp, e_d, e_new;
  logic [7:0]        e_clamped;
  logic [7:0]        att_c, ak_c;

  always_comb begin
    att9 = {1'b0, sr.hit_ent.att} + 9'd1;
    if (att9 > 9'd255) att9 = 9'd255;
    ak9 = {1'b0, sr.hit_ent.ack} + {8'd0, ack_q};
    if (ak9 > att9) ak9 = att9;
    att_c = att9[7:0];
    ak_c  = ak9[7:0];
    e_old = {2'b00, sr.hit_ent.etx};
    e_smp = ack_q ? {2'b00, mnlq_pkg::ETX_ONE} : {2'b00, mnlq_pkg::ETX_LOSS};
    e_d   = e_smp - e_old;
    e_new = e_old + (e_d >>> ewma_shift);
    if (e_new < 10'sd16)       e_clamped = mnlq_pkg::ETX_ONE;
    else if (e_new > 10'sd128) e_clamped = mnlq_pkg::ETX_CEIL;
    else                       e_clamped = e_new[7:0];
  end

  // RSSI averaging
  logic signed [9:0] r_old, r_smp, r_new;
  logic signed [7:0] rssi_next;

  always_comb begin
    r_old = 10'(sr.hit_ent.rssi);
    r_smp = 10'(rs_q);
    r_new = r_old + ((r_smp - r_old) >>> ewma_shift);
    if (sr.hit_ent.rssi == mnlq_pkg::RSSI_NONE) rssi_next = rs_q;
    else                                        rssi_next = r_new[7:0];
  end

  // cost from the new ETX and the stored RSSI
  logic signed [9:0] gap;
  logic [16:0]       cost17;
  logic [15:0]       cost_next;

  always_comb begin
    gap    = 10'(weak_rssi) - 10'(sr.hit_ent.rssi);
    cost17 = {9'd0, etx_q};
    if (sr.hit_ent.rssi != mnlq_pkg::RSSI_NONE && sr.hit_ent.rssi < weak_rssi) begin
      cost17 = cost17 + ({8'd0, gap[8:0]} * {13'd0, penalty});
    end
    cost_next = (cost17 > {1'b0, mnlq_pkg::COST_MAX}) ? mnlq_pkg::COST_MAX : cost17[15:0];
  end

  // result and write-back
  logic [1:0]                   status;
  logic [mnlq_pkg::IDX_W-1:0]   slot;
  logic                         shown_en;
  mnlq_pkg::entry_t             shown, upd;
  logic [1:0]                   kind;
  logic [mnlq_pkg::ADDR_W-1:0]  ev;
  logic [mnlq_pkg::CNT_W-1:0]   lnk;
  logic                         addr_op;
  mnlq_pkg::wr_t                wr_c;

  assign addr_op = op_q inside {mnlq_pkg::OP_FIND, mnlq_pkg::OP_ALLOC, mnlq_pkg::OP_TX,
                                mnlq_pkg::OP_RSSI, mnlq_pkg::OP_FREE, mnlq_pkg::OP_SET};

  always_comb begin
    status   = mnlq_pkg::STAT_OK;
    slot     = '0;
    shown_en = 1'b0;
    upd      = sr.hit_ent;
    shown    = sr.hit_ent;
    kind     = mnlq_pkg::KIND_FREE;
    ev       = '0;
    lnk      = sr.nlinked;
    wr_c     = '0;
    case (op_q)
      mnlq_pkg::OP_FIND: begin
        if (sr.hit) begin
          slot     = sr.hit_idx;
          shown_en = 1'b1;
        end else begin
          status = mnlq_pkg::STAT_MISS;
        end
      end
      mnlq_pkg::OP_ALLOC: begin
        if (sr.hit) begin
          slot     = sr.hit_idx;
          shown_en = 1'b1;
        end else if (sr.free) begin
          upd      = '0;
          upd.addr = addr_q;
          upd.st   = mnlq_pkg::ST_HEARD;
          upd.rssi = mnlq_pkg::RSSI_NONE;
          upd.etx  = mnlq_pkg::ETX_ONE;
          upd.cost = mnlq_pkg::COST_FRESH;
          slot     = sr.free_idx;
          shown    = upd;
          shown_en = 1'b1;
          wr_c     = '{en: 1'b1, idx: sr.free_idx, ent: upd};
        end else begin
          status = mnlq_pkg::STAT_MISS;
        end
      end
      mnlq_pkg::OP_TX: begin
        if (sr.hit) begin
          upd.etx  = etx_q;
          upd.att  = att_q;
          upd.ack  = ak_q;
          upd.loss = div_quo;
          upd.cost = cost_next;
          slot     = sr.hit_idx;
          shown    = upd;
          shown_en = 1'b1;
          wr_c     = '{en: 1'b1, idx: sr.hit_idx, ent: upd};
        end else begin
          status = mnlq_pkg::STAT_MISS;
        end
      end
      mnlq_pkg::OP_RSSI: begin
        if (sr.hit) begin
          upd.rssi = rssi_next;
          slot     = sr.hit_idx;
          shown    = upd;
          shown_en = 1'b1;
          wr_c     = '{en: 1'b1, idx: sr.hit_idx, ent: upd};
        end else begin
          status = mnlq_pkg::STAT_MISS;
        end
      end
      mnlq_pkg::OP_ROOM: begin
        if (sr.free) begin
          slot = sr.free_idx;
        end else if (sr.unl) begin
          slot = sr.unl_idx;
          kind = mnlq_pkg::KIND_UNLINKED;
          ev   = sr.unl_addr;
          wr_c = '{en: 1'b1, idx: sr.unl_idx, ent: '0};
        end else if (sr.lnk) begin
          slot = sr.lnk_idx;
          kind = mnlq_pkg::KIND_LINKED;
          ev   = sr.lnk_addr;
          lnk  = sr.nlinked - 1'b1;
          wr_c = '{en: 1'b1, idx: sr.lnk_idx, ent: '0};
        end else begin
          status = mnlq_pkg::STAT_MISS;
        end
      end
      mnlq_pkg::OP_FREE: begin
        if (sr.hit) begin
          slot = sr.hit_idx;
          if (sr.hit_ent.st == mnlq_pkg::ST_LINKED) lnk = sr.nlinked - 1'b1;
          wr_c = '{en: 1'b1, idx: sr.hit_idx, ent: '0};
        end else begin
          status = mnlq_pkg::STAT_MISS;
        end
      end
      mnlq_pkg::OP_SET: begin
        if (sr.hit) begin
          // a zero state leaves the link state alone
          if (nst_q != mnlq_pkg::ST_FREE) upd.st = nst_q;
          upd.par  = par_q;
          if (sr.hit_ent.st == mnlq_pkg::ST_LINKED) lnk = lnk - 1'b1;
          if (upd.st == mnlq_pkg::ST_LINKED)        lnk = lnk + 1'b1;
          slot     = sr.hit_idx;
          shown    = upd;
          shown_en = 1'b1;
          wr_c     = '{en: 1'b1, idx: sr.hit_idx, ent: upd};
        end else begin
          status = mnlq_pkg::STAT_MISS;
        end
      end
      default: begin
      end
    endcase
    if (addr_op && addr_q == invalid_addr) begin
      status   = mnlq_pkg::STAT_BADADDR;
      wr_c     = '0;
      shown_en = 1'b0;
      kind     = mnlq_pkg::KIND_FREE;
      ev       = '0;
      lnk      = sr.nlinked;
    end
    if (status != mnlq_pkg::STAT_OK) begin
      slot     = '0;
      shown_en = 1'b0;
      kind     = mnlq_pkg::KIND_FREE;
      ev       = '0;
    end
  end

  logic fin_go;
  assign fin_go = (state == S_FIN) && (!m_tvalid || m_tready);

  always_comb begin
    wr    = wr_c;
    wr.en = wr_c.en && fin_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      start_q      <= 1'b0;
      div_start    <= 1'b0;
      m_tvalid     <= 1'b0;
      ewma_shift   <= 3'd3;
      weak_rssi    <= -8'sd88;
      penalty      <= 4'd2;
      invalid_addr <= 16'hFFFF;
    end else begin
      start_q   <= 1'b0;
      div_start <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mnlq_pkg::CFG_EWMA:    ewma_shift   <= cfg_data[2:0];
          mnlq_pkg::CFG_WEAK:    weak_rssi    <= cfg_data[7:0];
          mnlq_pkg::CFG_PENALTY: penalty      <= cfg_data[3:0];
          mnlq_pkg::CFG_INVALID: invalid_addr <= cfg_data;
          default: begin
          end
        endcase
      end
      // load a new result beat, else drop the one just taken
      if (fin_go)        m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            start_q <= 1'b1;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_res.vld) begin
            if (op_q == mnlq_pkg::OP_TX && scan_res.hit) state <= S_MATH;
            else                                         state <= S_FIN;
          end
        end
        S_MATH: begin
          div_start <= 1'b1;
          state     <= S_DIV;
        end
        S_DIV: begin
          if (div_done) state <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      op_q   <= s_tuser[2:0];
      addr_q <= s_tdata[15:0];
      ack_q  <= s_tdata[16];
      rs_q   <= s_tdata[24:17];
      cand_q <= s_tdata[40:25];
      nst_q  <= s_tdata[42:41];
      par_q  <= s_tdata[43];
    end
    if (state == S_SCAN && scan_res.vld) sr <= scan_res;
    if (state == S_MATH) begin
      etx_q <= e_clamped;
      den_q <= att_c;
      num_q <= {10'd0, att_c - ak_c} * {8'd0, mnlq_pkg::PERMILLE};
      // halve after the loss rate has taken the full counts
      if (att_c >= mnlq_pkg::HALVE_AT) begin
        att_q <= att_c >> 1;
        ak_q  <= ak_c >> 1;
      end else begin
        att_q <= att_c;
        ak_q  <= ak_c;
      end
    end
    if (fin_go) begin
      m_tuser <= {kind, status};
      m_tdata <= {7'd0, ev, lnk[3:0],
                  shown_en ? shown.rssi : 8'd0,
                  shown_en ? shown.loss : 10'd0,
                  shown_en ? shown.etx  : 8'd0,
                  shown_en ? shown.cost : 16'd0,
                  slot[2:0]};
    end
  end

endmodule

// File: sv/mesh_neighbor_link_quality_table.sv
// Path: find, alloc, rssi, make room, free, set and count go from the accepted beat
// through the start register, each slot cell in turn and the scan capture to the
// registered result beat; a transmit result adds the ETX step and the bit-serial
// loss-rate divider. Throughput: one request at a time; the next beat is taken
// after its result beat is loaded, which waits while an earlier result is not taken.
// Reset: every slot free, configuration registers at their defaults, both streams empty.
module mesh_neighbor_link_quality_table #(
  parameter int SLOTS = mnlq_pkg::SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // peer_addr, ack_ok, rssi_sample, candidate_cost, new_link_state, parent_flag
  input  logic [mnlq_pkg::IN_DATA_W-1:0]    s_tdata,
  // op
  input  logic [mnlq_pkg::IN_USER_W-1:0]    s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // slot, out_cost, out_etx, out_loss_permille, out_rssi, linked_total, evicted_addr
  output logic [mnlq_pkg::OUT_DATA_W-1:0]   m_tdata,
  // status, evict_kind
  output logic [mnlq_pkg::OUT_USER_W-1:0]   m_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mnlq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mnlq_pkg::CFG_DATA_W-1:0]   cfg_data
);

  mnlq_pkg::key_t  key;
  mnlq_pkg::wr_t   wr;
  mnlq_pkg::scan_t chain [SLOTS+1];

  mnlq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key),
    .scan_init (chain[0]),
    .scan_res  (chain[SLOTS]),
    .wr        (wr)
  );

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    mnlq_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .key      (key),
      .wr       (wr),
      .scan_in  (chain[i]),
      .scan_out (chain[i+1])
    );
  end

endmodule
